### sv/lirr_pkg.sv
// Shared constants for the linear interpolating rational resampler.
`default_nettype none
package lirr_pkg;

  // Default field widths
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FACTOR_BITS_DEF = 16;

  // Configuration register indexes
  localparam logic REG_UP_FACTOR   = 1'b0;
  localparam logic REG_DOWN_FACTOR = 1'b1;

endpackage
`default_nettype wire

### sv/lirr_serdiv.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module lirr_serdiv #(
  parameter int DW = 33,
  parameter int FB = 16,
  parameter int LW = $clog2(DW + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [LW-1:0] len,       // number of dividend bits, taken from the top
  input  wire logic [DW-1:0] dividend,  // left aligned
  input  wire logic [FB-1:0] divisor,   // nonzero
  output logic               done,
  output logic [DW-1:0]      quotient,
  output logic [FB-1:0]      remainder
);

  logic          busy_r;
  logic          done_r;
  logic [LW-1:0] cnt_r;
  logic [DW-1:0] dvd_r;
  logic [FB-1:0] rem_r;

  logic [FB:0]   rem_sh;
  logic [FB+1:0] diff;
  logic          ge;

  // Shift in the next dividend bit and try to subtract the divisor
  always_comb begin
    rem_sh = {rem_r, dvd_r[DW-1]};
    diff   = {1'b0, rem_sh} - {2'b00, divisor};
    ge     = !diff[FB+1];
  end

  // Sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= len;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == LW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Dividend and remainder; quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DW-2:0], ge};
      rem_r <= ge ? diff[FB-1:0] : rem_sh[FB-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = dvd_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

### sv/linear_interp_rational_resampler.sv
// One word at a time: a new word is accepted only in the idle state, once the serial
//   divider (phase modulo, interpolation quotient, next phase), the shift-add multiplier
//   and the result words for the last word are done. The first word of a stream is
//   only stored, unless it also ends the stream.
// Reset (rst_n low at a clock edge): factors return to 1, the stream state is cleared
//   and no result is pending.
`default_nettype none
module linear_interp_rational_resampler
  import lirr_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FACTOR_BITS = FACTOR_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // configuration
  input  wire logic                                 cfg_we,
  input  wire logic                                 cfg_addr,
  input  wire logic [FACTOR_BITS-1:0]               cfg_wdata,
  // input stream
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]     in_tdata,   // sample_in
  input  wire logic                                 in_tlast,   // stream_end
  // result stream
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]          out_tdata,  // sample_out
  output logic                                      out_tuser,  // sample_valid
  output logic                                      out_tlast   // last_out
);

  localparam int SB = SAMPLE_BITS;
  localparam int FB = FACTOR_BITS;
  localparam int DW = SB + 1 + FB;
  localparam int LW = $clog2(DW + 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_MOD1  = 8'b00000010,
    S_PREP  = 8'b00000100,
    S_MUL   = 8'b00001000,
    S_DIV   = 8'b00010000,
    S_MOD2  = 8'b00100000,
    S_EMIT1 = 8'b01000000,
    S_EMIT2 = 8'b10000000
  } state_t;

  state_t        state_r, state_nxt;

  logic [FB-1:0] up_r, down_r;
  logic [SB-1:0] prev_r;
  logic          have_prev_r;
  logic [FB-1:0] phase_r;

  logic [SB-1:0] x_r;
  logic          end_r;
  logic [FB-1:0] ph_r;
  logic          need_r;
  logic [SB:0]   mag_r;
  logic          neg_r;
  logic [DW-1:0] acc_r;
  logic [FB-1:0] mt_r;
  logic [LW-1:0] mcnt_r;
  logic [SB-1:0] pt_r;
  logic [SB-1:0] fin_r;
  logic          fin_sv_r;

  logic          out_valid_r;
  logic [SB-1:0] out_sample_r;
  logic          out_sv_r;
  logic          out_last_r;

  logic [FB-1:0] l_eff, m_eff;
  logic          down_ok;
  logic          in_acc, out_free;
  logic [SB-1:0] x_in;
  logic [FB-1:0] t_w;
  logic          need_w;
  logic [SB:0]   d_w, mag_w;
  logic [FB:0]   sum2;
  logic [SB:0]   pt_w;
  logic [SB-1:0] fin_w;
  logic          fin_sv_w;

  logic          div_start;
  logic [LW-1:0] div_len;
  logic [DW-1:0] div_dividend;
  logic          div_done;
  logic [DW-1:0] div_q;
  logic [FB-1:0] div_rem;

  // Effective factors: zero counts as one
  always_comb begin
    l_eff   = (up_r == '0) ? FB'(1) : up_r;
    m_eff   = (down_r == '0) ? FB'(1) : down_r;
    down_ok = l_eff <= m_eff;
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign x_in      = in_tdata[SB-1:0];
  assign out_free  = !out_valid_r || out_tready;

  // Segment offset of the kept point and the sample difference
  always_comb begin
    t_w    = (ph_r == '0) ? '0 : m_eff - ph_r;
    need_w = down_ok && (t_w < l_eff);
    d_w    = {x_r[SB-1], x_r} - {prev_r[SB-1], prev_r};
    mag_w  = d_w[SB] ? -d_w : d_w;
    sum2   = {1'b0, ph_r} + {1'b0, l_eff};
    pt_w   = neg_r ? ({prev_r[SB-1], prev_r} - div_q[SB:0])
                   : ({prev_r[SB-1], prev_r} + div_q[SB:0]);
  end

  // Final word of a stream, from the next phase
  always_comb begin
    fin_w    = (div_rem == '0) ? x_r : '0;
    fin_sv_w = (div_rem == '0);
  end

  // Divider requests
  always_comb begin
    div_start    = 1'b0;
    div_len      = LW'(FB);
    div_dividend = {phase_r, {(SB + 1){1'b0}}};
    case (state_r)
      S_IDLE: begin
        div_start = in_acc && have_prev_r;
      end
      S_PREP: begin
        div_start    = !need_w;
        div_len      = LW'(FB + 1);
        div_dividend = {sum2, {SB{1'b0}}};
      end
      S_MUL: begin
        div_start    = (mcnt_r == '0);
        div_len      = LW'(DW);
        div_dividend = acc_r;
      end
      S_DIV: begin
        div_start    = div_done;
        div_len      = LW'(FB + 1);
        div_dividend = {sum2, {SB{1'b0}}};
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (have_prev_r)
            state_nxt = S_MOD1;
          else if (in_tlast && down_ok)
            state_nxt = S_EMIT2;
        end
      end
      S_MOD1: begin
        if (div_done) state_nxt = S_PREP;
      end
      S_PREP: begin
        state_nxt = need_w ? S_MUL : S_MOD2;
      end
      S_MUL: begin
        if (mcnt_r == '0) state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) state_nxt = S_MOD2;
      end
      S_MOD2: begin
        if (div_done) begin
          if (need_r)
            state_nxt = S_EMIT1;
          else if (end_r && down_ok)
            state_nxt = S_EMIT2;
          else
            state_nxt = S_IDLE;
        end
      end
      S_EMIT1: begin
        if (out_free) state_nxt = (end_r && down_ok) ? S_EMIT2 : S_IDLE;
      end
      S_EMIT2: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and stream state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      up_r        <= FB'(1);
      down_r      <= FB'(1);
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      phase_r     <= '0;
      mcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_addr)
          REG_UP_FACTOR:   up_r   <= cfg_wdata;
          REG_DOWN_FACTOR: down_r <= cfg_wdata;
          default: ;
        endcase
      end

      // first word of a stream
      if (in_acc && !have_prev_r) begin
        if (in_tlast) begin
          prev_r      <= '0;
          have_prev_r <= 1'b0;
        end else begin
          prev_r      <= x_in;
          have_prev_r <= 1'b1;
        end
        phase_r <= '0;
      end

      // advance or restart the stream once the next phase is known
      if (state_r == S_MOD2 && div_done) begin
        if (end_r) begin
          prev_r      <= '0;
          have_prev_r <= 1'b0;
          phase_r     <= '0;
        end else begin
          prev_r  <= x_r;
          phase_r <= div_rem;
        end
      end

      // multiplier bit count
      if (state_r == S_PREP)
        mcnt_r <= LW'(FB);
      else if (state_r == S_MUL && mcnt_r != '0)
        mcnt_r <= mcnt_r - 1'b1;

      // output register
      if ((state_r == S_EMIT1 || state_r == S_EMIT2) && out_free)
        out_valid_r <= 1'b1;
      else if (out_tready)
        out_valid_r <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r   <= x_in;
      end_r <= in_tlast;
      if (!have_prev_r) begin
        fin_r    <= x_in;
        fin_sv_r <= 1'b1;
      end
    end
    if (state_r == S_MOD1 && div_done)
      ph_r <= div_rem;
    if (state_r == S_PREP) begin
      need_r <= need_w;
      mag_r  <= mag_w;
      neg_r  <= d_w[SB];
      acc_r  <= '0;
      mt_r   <= t_w;
    end
    // shift-add multiply, offset bits from the top
    if (state_r == S_MUL && mcnt_r != '0) begin
      acc_r <= {acc_r[DW-2:0], 1'b0} + (mt_r[FB-1] ? DW'(mag_r) : '0);
      mt_r  <= {mt_r[FB-2:0], 1'b0};
    end
    if (state_r == S_DIV && div_done)
      pt_r <= pt_w[SB-1:0];
    if (state_r == S_MOD2 && div_done) begin
      fin_r    <= fin_w;
      fin_sv_r <= fin_sv_w;
    end
    if (state_r == S_EMIT1 && out_free) begin
      out_sample_r <= pt_r;
      out_sv_r     <= 1'b1;
      out_last_r   <= 1'b0;
    end else if (state_r == S_EMIT2 && out_free) begin
      out_sample_r <= fin_r;
      out_sv_r     <= fin_sv_r;
      out_last_r   <= 1'b1;
    end
  end

  lirr_serdiv #(
    .DW (DW),
    .FB (FB),
    .LW (LW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .len       (div_len),
    .dividend  (div_dividend),
    .divisor   (state_r == S_DIV ? l_eff : m_eff),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // Drive the result ports
  always_comb begin
    out_tdata         = '0;
    out_tdata[SB-1:0] = out_sample_r;
  end
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_sv_r;
  assign out_tlast  = out_last_r;

  // Reduced phase lies below the decimation factor
  a_phase_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PREP |-> ph_r < m_eff)
    else $error("reduced phase not below decimation factor");

  // Interpolation quotient never exceeds the sample difference width
  a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && div_done) |-> div_q[DW-1:SB+1] == '0)
    else $error("interpolation quotient overflow");

  // An interpolated point is never the stream's last word
  a_point_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT1 && out_free) |=> (out_valid_r && !out_last_r))
    else $error("interpolated point marked last");

endmodule
`default_nettype wire

### sim/tb_top.sv
// Testbench for the linear interpolating rational resampler: random streams checked word by word.
`timescale 1ns / 1ps
module tb_top;
  import lirr_pkg::*;

  localparam int DRAIN_CYCLES = 120;   // above the longest per-word latency
  localparam int STALL_LIMIT  = 4000;  // cycles without any handshake before giving up
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    logic signed [15:0] smp;
    logic               vld;
    logic               lst;
  } sample_res_t;

  typedef struct {
    logic [15:0] smp;
    bit          fin;
  } src_word_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic        cfg_addr   = REG_UP_FACTOR;
  logic [15:0] cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;   // sample_in
  logic        in_tlast   = 1'b0; // stream_end
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // sample_out
  logic        out_tuser;         // sample_valid
  logic        out_tlast;         // last_out

  linear_interp_rational_resampler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Source words waiting to be sent and resampled words still owed by the block
  src_word_t   src_q[$];
  sample_res_t resampled_q[$];

  // Predictor copy of the factors and stream state
  logic [15:0]        up_l = 16'd1;
  logic [15:0]        down_m = 16'd1;
  logic signed [15:0] last_smp = '0;
  bit                 have_last = 1'b0;
  logic [15:0]        pos_phase = '0;

  int mismatches = 0;
  int idle_pct = 20;
  bit hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Advance the stream state by one source word and queue the words it yields
  function automatic void resample_step(input logic signed [15:0] x, input bit fin);
    longint      l, m, ph, t, np, d, mag, off;
    bit          down_ok;
    sample_res_t r;
    l = (up_l == 0) ? 1 : up_l;
    m = (down_m == 0) ? 1 : down_m;
    down_ok = (l <= m);
    if (!have_last) begin
      if (fin) begin
        if (down_ok) begin
          r = '{x, 1'b1, 1'b1};
          resampled_q.insert(resampled_q.size(), r);
        end
        last_smp = '0;
        pos_phase = '0;
      end else begin
        last_smp = x;
        have_last = 1'b1;
        pos_phase = '0;
      end
      return;
    end
    ph = pos_phase % m;
    t = (m - ph) % m;
    // kept point inside the segment: truncated toward zero
    if (down_ok && t < l) begin
      d = longint'(x) - longint'(last_smp);
      mag = (d < 0) ? -d : d;
      off = (mag * t) / l;
      r.smp = 16'((d < 0) ? longint'(last_smp) - off : longint'(last_smp) + off);
      r.vld = 1'b1;
      r.lst = 1'b0;
      resampled_q.insert(resampled_q.size(), r);
    end
    np = (ph + l) % m;
    if (fin) begin
      // closing word: the sample itself if it lands on a kept position, else a bare marker
      if (down_ok) begin
        r.smp = (np == 0) ? x : 16'sd0;
        r.vld = (np == 0);
        r.lst = 1'b1;
        resampled_q.insert(resampled_q.size(), r);
      end
      last_smp = '0;
      have_last = 1'b0;
      pos_phase = '0;
    end else begin
      last_smp = x;
      pos_phase = np[15:0];
    end
  endfunction

  // Sender: offer queued words, with random gaps between them
  int src_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) resample_step(in_tdata, in_tlast);
      if (!in_tvalid || in_tready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          in_tvalid <= 1'b0;
        end else if (src_q.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if ($urandom_range(0, 99) < idle_pct) begin
          src_gap <= $urandom_range(0, 6);
          in_tvalid <= 1'b0;
        end else begin
          in_tvalid <= 1'b1;
          in_tdata <= src_q[0].smp;
          in_tlast <= src_q[0].fin;
          void'(src_q.pop_front());
        end
      end
    end
  end

  // Receiver: stall in random bursts, plus one long hold-off on request
  int  rx_stall = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      rx_stall <= $urandom_range(0, 6);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: compare each accepted word with the oldest prediction
  always @(posedge clk) begin
    sample_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (resampled_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected word data=%0d valid=%0b last=%0b",
                                $signed(out_tdata), out_tuser, out_tlast));
      end else begin
        want = resampled_q.pop_front();
        if (out_tdata !== want.smp)
          flag_mismatch($sformatf("sample_out %0d, want %0d", $signed(out_tdata), want.smp));
        if (out_tuser !== want.vld)
          flag_mismatch($sformatf("sample_valid %0b, want %0b", out_tuser, want.vld));
        if (out_tlast !== want.lst)
          flag_mismatch($sformatf("last_out %0b, want %0b", out_tlast, want.lst));
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_word(input logic [15:0] smp, input bit fin);
    src_word_t w;
    w.smp = smp;
    w.fin = fin;
    src_q.insert(src_q.size(), w);
  endtask

  // Hold until every word is sent and answered, then let the block settle
  task automatic wait_drained();
    do @(posedge clk); while (src_q.size() != 0 || in_tvalid || resampled_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_factors(input logic [15:0] l, input logic [15:0] m);
    wait_drained();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= REG_UP_FACTOR;
    cfg_wdata <= l;
    @(posedge clk);
    cfg_addr <= REG_DOWN_FACTOR;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    up_l = l;
    down_m = m;
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 15) - 8);
      default: return 16'($urandom());
    endcase
  endfunction

  // Queue n random words as streams of random length; close the last one if asked
  task automatic queue_streams(input int n, input bit close_last);
    int cnt, len;
    cnt = 0;
    while (cnt < n) begin
      len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 40);
      for (int i = 0; i < len && cnt < n; i++) begin
        cnt++;
        push_word(pick_sample(), (i == len - 1) || (close_last && cnt == n));
      end
    end
  endtask

  task automatic run_phase(input int l, input int m, input int n, input int pct);
    set_factors(l[15:0], m[15:0]);
    idle_pct = pct;
    queue_streams(n, 1'b0);
  endtask

  initial begin
    int l;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset factors, single-word stream and a two-word stream at full scale
    idle_pct = 15;
    push_word(16'h8000, 1'b1);
    push_word(16'h7fff, 1'b0);
    push_word(16'h8000, 1'b1);
    // zero factors act as one
    set_factors(16'd0, 16'd0);
    push_word(16'd100, 1'b0);
    push_word(16'hffff, 1'b1);
    // 3/5: interpolation at full swing, end on a bare marker, then end on a kept sample
    set_factors(16'd3, 16'd5);
    push_word(16'h8000, 1'b0);
    push_word(16'h7fff, 1'b0);
    push_word(16'h8000, 1'b0);
    push_word(16'h7fff, 1'b0);
    push_word(16'h0000, 1'b0);
    push_word(16'hffff, 1'b0);
    push_word(16'd12345, 1'b1);
    push_word(16'h7fff, 1'b0);
    push_word(16'h8000, 1'b0);
    push_word(16'd1, 1'b0);
    push_word(16'hfffe, 1'b0);
    push_word(16'h7fff, 1'b0);
    push_word(16'h8000, 1'b1);
    // upsampling yields nothing, not even at the end of a stream
    set_factors(16'd5, 16'd3);
    push_word(16'd1, 1'b0);
    push_word(16'd2, 1'b0);
    push_word(16'd3, 1'b1);
    push_word(16'h7fff, 1'b1);
    // largest equal factors
    set_factors(16'hffff, 16'hffff);
    push_word(16'h7fff, 1'b0);
    push_word(16'h8000, 1'b1);

    // Random: unity rate with a long receiver hold-off to back up the input
    run_phase(1, 1, 250, 20);
    hold_req = 1'b1;
    run_phase(2, 3, 150, 10);
    run_phase(3, 7, 120, 35);
    run_phase(40000, 65535, 100, 15);
    run_phase(1, 65535, 40, 20);
    run_phase(65535, 1, 60, 20);
    run_phase(0, 4, 60, 25);
    run_phase(9, 0, 30, 10);
    repeat (4) begin
      l = $urandom_range(1, 16);
      run_phase(l, $urandom_range(l, 24), 80, $urandom_range(0, 40));
    end
    run_phase(65534, 65535, 80, 10);

    // Last part without idling; close the final stream
    set_factors(16'd3, 16'd4);
    idle_pct = 0;
    queue_streams(150, 1'b1);
    wait_drained();

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
